// ===== rtl/core/pgss_pkg.sv =====
// shared types, constants and helpers for the panorama grid scan sequencer
// no dependencies; imported by panorama_grid_scan_sequencer
package pgss_pkg;

  // largest number of panels along one axis
  localparam int unsigned MAX_PANELS = 1024;
  localparam int unsigned AXIS_W     = $clog2(MAX_PANELS + 1);

  // register widths fixed by the register map
  localparam int unsigned POS_W   = 32;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned REP_W   = 16;
  localparam int unsigned IMG_W   = 21;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned PROD_W  = AXIS_W + STEP_W;
  localparam int unsigned DCNT_W  = $clog2(IMG_W);

  // stream widths
  localparam int unsigned S_DATA_W = 8;
  localparam int unsigned M_DATA_W = 72;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_STEP_X    = 3'd2,
    CFG_STEP_Y    = 3'd3,
    CFG_COLUMNS   = 3'd4,
    CFG_ROWS      = 3'd5,
    CFG_FLAGS     = 3'd6,
    CFG_REPEATS   = 3'd7
  } cfg_idx_e;

  // scan flag bit positions
  localparam int unsigned FLAG_START_LEFT = 0;
  localparam int unsigned FLAG_START_TOP  = 1;
  localparam int unsigned FLAG_ROW_FIRST  = 2;
  localparam int unsigned FLAG_SERPENTINE = 3;

  // scan phase as seen on the result
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MOVE  = 2'd1,
    PH_SHOOT = 2'd2
  } phase_e;

  // sequencer states of the target planner
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MULX,
    ST_MULY,
    ST_ADDY
  } seq_state_e;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [CNT_W-1:0] n);
    logic [AXIS_W-1:0] r;
    if (n == '0) begin
      r = AXIS_W'(1);
    end else if (32'(n) > MAX_PANELS) begin
      r = AXIS_W'(MAX_PANELS);
    end else begin
      r = AXIS_W'(n);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/panorama_grid_scan_sequencer.sv =====
// panorama grid scan sequencer: idle/move/shoot machine with target planner
// depends on pgss_pkg (constants, phase and state enums, axis clamp)
// results: poll, arm and no-op items load the result register at accept, so it shows in the next cycle
// items that issue a new target pass the divide, x multiply, y multiply and add states before their
//   result is registered, using the one-bit-per-cycle restoring divider and the multiplier shared by x then y
// throughput: one item at a time, the input is not ready while a target is planned
// reset: phase idle, image and repeat counts zero, registers at their reset values
module panorama_grid_scan_sequencer
  import pgss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [POS_W-1:0]      cfg_data_i,
  // input item stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [S_DATA_W-1:0]   s_axis_tdata_i,   // motion_done, camera_done, zero fill
  input  logic                  s_axis_tuser_i,   // req_type
  // result item stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [M_DATA_W-1:0]   m_axis_tdata_o    // busy_res, move_cmd, target_x[32],
                                                  // target_y[32], shoot_cmd, phase[2], fill
);

  // configuration registers
  logic [POS_W-1:0]   origin_x_q, origin_y_q;
  logic [STEP_W-1:0]  step_x_q, step_y_q;
  logic [CNT_W-1:0]   column_count_q, row_count_q;
  logic [FLAGS_W-1:0] scan_flags_q;
  logic [REP_W-1:0]   repeat_limit_q;

  // scan state
  phase_e             phase_q, phase_d;
  logic [IMG_W-1:0]   image_count_q, image_count_d;
  logic [REP_W-1:0]   repeat_count_q, repeat_count_d;

  // planner
  seq_state_e         st_q, st_d;
  logic [IMG_W-1:0]   dvd_q;          // dividend, shifts into quotient
  logic [AXIS_W-1:0]  rem_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [PROD_W-1:0]  prod_q;
  logic [POS_W-1:0]   tx_q;

  // output register
  logic               m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      step_x_q       <= '0;
      step_y_q       <= '0;
      column_count_q <= CNT_W'(1);
      row_count_q    <= CNT_W'(1);
      scan_flags_q   <= FLAGS_W'(7);
      repeat_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: origin_x_q     <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q     <= cfg_data_i;
        CFG_STEP_X:   step_x_q       <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_Y:   step_y_q       <= cfg_data_i[STEP_W-1:0];
        CFG_COLUMNS:  column_count_q <= cfg_data_i[CNT_W-1:0];
        CFG_ROWS:     row_count_q    <= cfg_data_i[CNT_W-1:0];
        CFG_FLAGS:    scan_flags_q   <= cfg_data_i[FLAGS_W-1:0];
        CFG_REPEATS:  repeat_limit_q <= cfg_data_i[REP_W-1:0];
        default: ;
      endcase
    end
  end

  // grid geometry
  logic [AXIS_W-1:0]   cols, rows, len;
  logic [2*AXIS_W-1:0] total;
  logic                row_first;

  assign cols      = clamp_axis(column_count_q);
  assign rows      = clamp_axis(row_count_q);
  assign row_first = scan_flags_q[FLAG_ROW_FIRST];
  // primary axis length is the divisor
  assign len       = row_first ? cols : rows;
  assign total     = (2*AXIS_W)'(cols) * (2*AXIS_W)'(rows);

  // input handshake: one item at a time, and only when the result slot frees
  logic acc;
  logic motion_done, camera_done, req_arm;

  assign s_axis_tready_o = (st_q == ST_IDLE) && (!m_valid_q || m_axis_tready_i);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign req_arm         = s_axis_tuser_i;
  assign motion_done     = s_axis_tdata_i[0];
  assign camera_done     = s_axis_tdata_i[1];

  // step decision for an accepted item
  logic             busy, shoot, plan;
  logic [IMG_W-1:0] img_inc;

  assign img_inc = image_count_q + IMG_W'(1);

  always_comb begin
    busy           = 1'b1;
    shoot          = 1'b0;
    plan           = 1'b0;
    phase_d        = phase_q;
    image_count_d  = image_count_q;
    repeat_count_d = repeat_count_q;
    if (req_arm) begin
      image_count_d  = '0;
      repeat_count_d = '0;
      phase_d        = PH_IDLE;
      busy           = 1'b0;
    end else begin
      case (phase_q)
        PH_MOVE: begin
          if (motion_done) begin
            shoot   = 1'b1;
            phase_d = PH_SHOOT;
          end
        end
        PH_SHOOT: begin
          if (camera_done) begin
            image_count_d = img_inc;
            // last image of the pass ends the sequence
            if (32'(img_inc) >= 32'(total)) begin
              phase_d = PH_IDLE;
              busy    = 1'b0;
            end else begin
              phase_d = PH_MOVE;
              plan    = 1'b1;
            end
          end
        end
        default: begin
          // idle, and a stale phase code also counts as idle
          phase_d = PH_IDLE;
          if (repeat_count_q < repeat_limit_q) begin
            repeat_count_d = repeat_count_q + REP_W'(1);
            image_count_d  = '0;
            phase_d        = PH_MOVE;
            plan           = 1'b1;
          end else begin
            busy = 1'b0;
          end
        end
      endcase
    end
  end

  // restoring divide step: image index / primary length
  logic [AXIS_W:0]   rem_sh;
  logic              div_ge;
  logic [AXIS_W-1:0] rem_nx;
  logic [AXIS_W:0]   rem_diff;

  assign rem_sh   = {rem_q, dvd_q[IMG_W-1]};
  assign div_ge   = rem_sh >= {1'b0, len};
  assign rem_diff = rem_sh - {1'b0, len};
  assign rem_nx   = div_ge ? rem_diff[AXIS_W-1:0] : rem_sh[AXIS_W-1:0];

  // index to grid cell: serpentine fold and start corner flips
  logic [AXIS_W-1:0] prim, sec, sec_m, row_r, col_r, row_c, col_c;

  assign prim  = dvd_q[AXIS_W-1:0];
  assign sec   = rem_q;
  assign sec_m = (scan_flags_q[FLAG_SERPENTINE] && prim[0]) ? (len - AXIS_W'(1) - sec) : sec;
  assign row_r = row_first ? prim : sec_m;
  assign col_r = row_first ? sec_m : prim;
  assign row_c = scan_flags_q[FLAG_START_TOP]  ? row_r : (rows - AXIS_W'(1) - row_r);
  assign col_c = scan_flags_q[FLAG_START_LEFT] ? col_r : (cols - AXIS_W'(1) - col_r);

  // shared multiplier: column times x step, then row times y step
  logic [AXIS_W-1:0] mul_a;
  logic [STEP_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  assign mul_a = (st_q == ST_MULX) ? col_c : row_c;
  assign mul_b = (st_q == ST_MULX) ? step_x_q : step_y_q;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // next planner state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (acc && plan) st_d = ST_DIV;
      ST_DIV:  if (dcnt_q == '0) st_d = ST_MULX;
      ST_MULX: st_d = ST_MULY;
      ST_MULY: st_d = ST_ADDY;
      ST_ADDY: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= ST_IDLE;
      phase_q        <= PH_IDLE;
      image_count_q  <= '0;
      repeat_count_q <= '0;
    end else begin
      st_q <= st_d;
      if (acc) begin
        phase_q        <= phase_d;
        image_count_q  <= image_count_d;
        repeat_count_q <= repeat_count_d;
      end
    end
  end

  // planner datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (acc && plan) begin
          dvd_q  <= image_count_d;
          rem_q  <= '0;
          dcnt_q <= DCNT_W'(IMG_W - 1);
        end
      end
      ST_DIV: begin
        dvd_q  <= {dvd_q[IMG_W-2:0], div_ge};
        rem_q  <= rem_nx;
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      ST_MULX: prod_q <= mul_p;
      ST_MULY: begin
        tx_q   <= origin_x_q + POS_W'(prod_q);
        prod_q <= mul_p;
      end
      default: ;
    endcase
  end

  // result register
  function automatic logic [M_DATA_W-1:0] pack_out(
    input logic             b, input logic m, input logic [POS_W-1:0] x,
    input logic [POS_W-1:0] y, input logic s, input logic [1:0] p);
    return M_DATA_W'({p, s, y, x, m, b});
  endfunction

  logic m_load_now, m_load_plan;

  // immediate results load at accept, planned ones once both targets are ready
  assign m_load_now  = acc && !plan;
  assign m_load_plan = (st_q == ST_ADDY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_load_now || m_load_plan) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load_now) begin
      m_data_q <= pack_out(busy, 1'b0, '0, '0, shoot, phase_d);
    end else if (m_load_plan) begin
      m_data_q <= pack_out(1'b1, 1'b1, tx_q, origin_y_q - POS_W'(prod_q), 1'b0, PH_MOVE);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== tb/sv/panorama_grid_scan_sequencer_test.sv =====
// self-checking test of the panorama grid scan sequencer: random and directed
// poll/arm traffic with a scoreboard class that predicts every result item
// depends on pgss_pkg and panorama_grid_scan_sequencer
module panorama_grid_scan_sequencer_test;
  import pgss_pkg::*;

  // one predicted result item, fields as they appear on the result stream
  typedef struct {
    bit        busy;
    bit        move;
    bit [31:0] tx;
    bit [31:0] ty;
    bit        shoot;
    bit [1:0]  ph;
  } scan_step_t;

  // scan tracker: holds its own copy of the registers and the sequencer state,
  // predicts one result per accepted request and checks results in order
  class grid_scan_tracker;
    bit [31:0]  org_x, org_y;
    bit [23:0]  stp_x, stp_y;
    bit [10:0]  n_cols, n_rows;
    bit [3:0]   flags;
    bit [15:0]  rep_limit;
    phase_e     ph;
    bit [20:0]  img;
    bit [15:0]  reps;
    scan_step_t expected_steps[$];
    int         mismatches, checked, moves, shots, passes;

    function new();
      org_x = '0; org_y = '0; stp_x = '0; stp_y = '0;
      n_cols = 11'd1; n_rows = 11'd1; flags = 4'd7; rep_limit = '0;
      ph = PH_IDLE; img = '0; reps = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, bit [31:0] v);
      case (idx)
        CFG_ORIGIN_X: org_x = v;
        CFG_ORIGIN_Y: org_y = v;
        CFG_STEP_X:   stp_x = v[23:0];
        CFG_STEP_Y:   stp_y = v[23:0];
        CFG_COLUMNS:  n_cols = v[10:0];
        CFG_ROWS:     n_rows = v[10:0];
        CFG_FLAGS:    flags = v[3:0];
        CFG_REPEATS:  rep_limit = v[15:0];
        default: ;
      endcase
    endfunction

    // zero panels count as one, more than the maximum saturate
    function int unsigned axis_len(bit [10:0] n);
      if (n == 0) return 1;
      if (n > MAX_PANELS) return MAX_PANELS;
      return n;
    endfunction

    // split the image index into row and column and turn it into a motor target
    function void aim(output bit [31:0] tx, output bit [31:0] ty);
      int unsigned cols, rows, len, prim, sec, row, col;
      cols = axis_len(n_cols);
      rows = axis_len(n_rows);
      len  = flags[FLAG_ROW_FIRST] ? cols : rows;
      prim = img / len;
      sec  = img % len;
      if (flags[FLAG_SERPENTINE] && prim[0]) sec = len - 1 - sec;
      row = flags[FLAG_ROW_FIRST] ? prim : sec;
      col = flags[FLAG_ROW_FIRST] ? sec : prim;
      if (!flags[FLAG_START_TOP]) row = rows - 1 - row;
      if (!flags[FLAG_START_LEFT]) col = cols - 1 - col;
      tx = org_x + col * stp_x;
      ty = org_y - row * stp_y;
      ph = PH_MOVE;
    endfunction

    function void note_request(bit req, bit md, bit cd);
      scan_step_t  s;
      int unsigned total;
      s = '{default: 0};
      s.busy = 1'b1;
      if (req) begin
        img = '0;
        reps = '0;
        ph = PH_IDLE;
        s.busy = 1'b0;
      end else begin
        case (ph)
          PH_MOVE: begin
            if (md) begin
              s.shoot = 1'b1;
              ph = PH_SHOOT;
              shots++;
            end
          end
          PH_SHOOT: begin
            if (cd) begin
              total = axis_len(n_cols) * axis_len(n_rows);
              img = img + 21'd1;
              if (img >= total) begin
                ph = PH_IDLE;
                s.busy = 1'b0;
                passes++;
              end else begin
                aim(s.tx, s.ty);
                s.move = 1'b1;
                moves++;
              end
            end
          end
          default: begin
            ph = PH_IDLE;
            if (reps < rep_limit) begin
              reps++;
              img = '0;
              aim(s.tx, s.ty);
              s.move = 1'b1;
              moves++;
            end else begin
              s.busy = 1'b0;
            end
          end
        endcase
      end
      s.ph = ph;
      expected_steps.push_back(s);
    endfunction

    function void compare_field(string name, bit [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] d);
      scan_step_t w;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected: %h", d);
        return;
      end
      w = expected_steps.pop_front();
      checked++;
      compare_field("busy_res", w.busy, d[0]);
      compare_field("move_cmd", w.move, d[1]);
      compare_field("target_x", w.tx, d[33:2]);
      compare_field("target_y", w.ty, d[65:34]);
      compare_field("shoot_cmd", w.shoot, d[66]);
      compare_field("phase", w.ph, d[68:67]);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [POS_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_DATA_W-1:0]  s_axis_tdata_i = '0;   // motion_done, camera_done, zero fill
  logic                 s_axis_tuser_i = 1'b0;  // req_type
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata_o;         // busy_res, move_cmd, target_x, target_y,
                                                // shoot_cmd, phase, zero fill

  grid_scan_tracker tracker = new();

  // quiet stretch: neither side idles while this is set
  bit quiet = 1'b0;
  int items_sent = 0;
  int settings_used = 0;

  panorama_grid_scan_sequencer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: stall about 6 percent of the time unless in a quiet stretch
  always @(posedge clk_i) begin
    m_axis_tready_i <= quiet || ($urandom_range(0, 99) >= 6);
  end

  // result monitor: values seen here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) tracker.check_result(m_axis_tdata_o);
  end

  // one request item; the prediction is made at the edge that accepts it
  task automatic send_request(bit req, bit md, bit cd);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {{(S_DATA_W-2){1'b0}}, cd, md};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_request(req, md, cd);
    items_sent++;
  endtask

  // register write; the caller drops the write enable after the last one
  task automatic write_reg(cfg_idx_e idx, bit [31:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    tracker.set_reg(idx, v);
  endtask

  // wait until every predicted result has come back, then let the planner drain
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.expected_steps.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic program_grid(bit [31:0] ox, bit [31:0] oy, bit [23:0] sx, bit [23:0] sy,
                              bit [10:0] cols, bit [10:0] rows, bit [3:0] fl,
                              bit [15:0] reps);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_STEP_X, 32'(sx));
    write_reg(CFG_STEP_Y, 32'(sy));
    write_reg(CFG_COLUMNS, 32'(cols));
    write_reg(CFG_ROWS, 32'(rows));
    write_reg(CFG_FLAGS, 32'(fl));
    write_reg(CFG_REPEATS, 32'(reps));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // positions: random half of the time, otherwise a signed extreme or zero
  function automatic bit [31:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [23:0] pick_step();
    case ($urandom_range(0, 4))
      0: return 24'h0;
      1: return 24'hff_ffff;
      2: return 24'($urandom_range(0, 4096));
      default: return 24'($urandom);
    endcase
  endfunction

  // panel counts: small grids so passes complete, sometimes zero, the
  // maximum, a saturating value or anything in range
  function automatic bit [10:0] pick_count();
    case ($urandom_range(0, 11))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd2047;
      3: return 11'($urandom_range(1, 2047));
      default: return 11'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic bit [15:0] pick_repeats();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin
    int rand_items;
    int n, k, r;
    rand_items = 0;
    k = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no repeats, so a poll leaves the sequencer idle
    send_request(1'b0, 1'b0, 1'b0);
    settle();

    // 2x2 serpentine grid at the position extremes, two passes
    program_grid(32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff, 24'hff_ffff,
                 11'd2, 11'd2, 4'hf, 16'd2);
    send_request(1'b0, 1'b0, 1'b0);   // start of first pass
    send_request(1'b0, 1'b0, 1'b0);   // still moving
    send_request(1'b0, 1'b1, 1'b0);   // arrived, shoot
    send_request(1'b0, 1'b0, 1'b0);   // exposure not finished
    send_request(1'b0, 1'b1, 1'b1);   // second panel
    send_request(1'b0, 1'b1, 1'b0);
    send_request(1'b0, 1'b0, 1'b1);   // third panel, mirrored line
    send_request(1'b0, 1'b1, 1'b0);
    send_request(1'b0, 1'b0, 1'b1);
    send_request(1'b0, 1'b1, 1'b0);
    send_request(1'b0, 1'b0, 1'b1);   // last image ends the pass
    send_request(1'b0, 1'b0, 1'b0);   // second pass starts
    send_request(1'b0, 1'b1, 1'b1);
    send_request(1'b1, 1'b1, 1'b1);   // arm while shooting
    send_request(1'b0, 1'b0, 1'b0);   // counts were cleared, starts again
    send_request(1'b1, 1'b0, 1'b0);   // arm while moving
    settle();

    // zero columns, saturating rows, bottom-right start, column first, raster
    program_grid(32'h0, 32'h0, 24'h00_0100, 24'h00_0001, 11'd0, 11'd2047, 4'h0,
                 16'hffff);
    send_request(1'b0, 1'b1, 1'b1);
    send_request(1'b0, 1'b1, 1'b0);
    send_request(1'b0, 1'b0, 1'b1);
    send_request(1'b0, 1'b1, 1'b0);
    send_request(1'b0, 1'b1, 1'b1);
    settle();

    // random part: one register setting per stretch of traffic, most items
    // follow the move/shoot handshake with random noise and arms mixed in
    while (rand_items < 500) begin
      quiet = (k == 2 || k == 3);
      program_grid(pick_pos(), pick_pos(), pick_step(), pick_step(), pick_count(),
                   pick_count(), 4'($urandom_range(0, 15)), pick_repeats());
      n = $urandom_range(40, 80);
      if ($urandom_range(0, 2) == 0) begin
        send_request(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        rand_items++;
      end
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_request(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (r < 15 || tracker.ph == PH_IDLE) begin
          send_request(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (tracker.ph == PH_MOVE) begin
          send_request(1'b0, 1'b1, 1'($urandom_range(0, 1)));
        end else begin
          send_request(1'b0, 1'($urandom_range(0, 1)), 1'b1);
        end
        rand_items++;
      end
      settle();
      k++;
    end
    quiet = 1'b0;

    $display("sent %0d request items over %0d register settings, %0d results checked",
             items_sent, settings_used, tracker.checked);
    $display("predicted %0d moves, %0d shots and %0d finished grid passes",
             tracker.moves, tracker.shots, tracker.passes);
    if (tracker.mismatches == 0 && tracker.expected_steps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches,
               tracker.expected_steps.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", tracker.expected_steps.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
